### sv/adbm_pkg.sv
// Shared types and constants for the arcade drive brake mixer.
package adbm_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_SQUARED_INPUTS = 1'b0;
  localparam logic REG_MAX_BRAKING    = 1'b1;

  localparam logic [3:0]  MAX_BRAKING_RESET   = 4'd4;
  localparam logic [15:0] TURN_IN_PLACE_LIMIT = 16'd2560;
  localparam logic [15:0] TURN_DEADBAND       = 16'd6400;
  localparam logic [19:0] BRAKE_SPAN          = 20'd26368;

  // Division by 6400 is a shift by 8 followed by a reciprocal multiply for 25.
  // The reciprocal is exact for every dividend below 2^20.
  localparam int          DB_SHIFT     = 8;
  localparam int          RECIP_SHIFT  = 25;
  localparam logic [20:0] RECIP_25     = 21'd1342178;

  typedef enum logic [1:0] {
    CMD_KEEP  = 2'd0,
    CMD_COAST = 2'd1,
    CMD_SET   = 2'd2
  } brake_cmd_t;

  // Output of the input shaping stages.
  typedef struct packed {
    logic signed [16:0] left_mix;
    logic signed [16:0] right_mix;
    logic [15:0]        afwd;
    logic [15:0]        aturn;
    logic               fneg;
    logic               tip;
    logic               in_db;
    logic               inb_left;
  } shape_t;

  // Output of the scaling stages.
  typedef struct packed {
    logic signed [16:0] left_mix;
    logic signed [16:0] right_mix;
    logic [15:0]        qmag;
    logic [3:0]         level;
    logic               fneg;
    logic               tip;
    logic               in_db;
    logic               inb_left;
  } scale_t;

  // One finished result item.
  typedef struct packed {
    logic signed [16:0] left_power;
    logic signed [16:0] right_power;
    brake_cmd_t         left_cmd;
    logic [3:0]         left_level;
    brake_cmd_t         right_cmd;
    logic [3:0]         right_level;
  } result_t;

endpackage

### sv/adbm_shape.sv
// Input shaping: optional signed squaring, magnitudes, mode flags and mixing sums.
module adbm_shape (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                squared_inputs,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic signed [15:0]  forward,
  input  logic signed [15:0]  turn,
  output logic                dn_valid,
  input  logic                dn_ready,
  output adbm_pkg::shape_t    dn_data
);
  import adbm_pkg::*;

  logic               v1_r, v2_r;
  logic               rdy1, rdy2;
  logic signed [15:0] fwd_r, trn_r;
  logic [15:0]        fsq_r, tsq_r;
  logic [15:0]        fabs_in, tabs_in;
  logic [31:0]        fprod, tprod;
  logic [15:0]        fsel, tsel, afwd, aturn;
  shape_t             s2_nxt, s2_r;

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // Stage 1: magnitudes and squares.
  always_comb begin
    fabs_in = forward[15] ? (~forward + 16'd1) : forward;
    tabs_in = turn[15] ? (~turn + 16'd1) : turn;
    fprod   = fabs_in * fabs_in;
    tprod   = tabs_in * tabs_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= up_valid;
    end
    if (rdy1 && up_valid) begin
      fwd_r <= forward;
      trn_r <= turn;
      fsq_r <= fprod[30:15];
      tsq_r <= tprod[30:15];
    end
  end

  // Stage 2: signed commands, flags and sums.
  always_comb begin
    if (squared_inputs) begin
      fsel = fwd_r[15] ? (~fsq_r + 16'd1) : fsq_r;
      tsel = trn_r[15] ? (~tsq_r + 16'd1) : tsq_r;
    end else begin
      fsel = fwd_r;
      tsel = trn_r;
    end
    afwd  = fsel[15] ? (~fsel + 16'd1) : fsel;
    aturn = tsel[15] ? (~tsel + 16'd1) : tsel;

    s2_nxt.afwd     = afwd;
    s2_nxt.aturn    = aturn;
    s2_nxt.fneg     = fsel[15];
    s2_nxt.tip      = afwd < TURN_IN_PLACE_LIMIT;
    s2_nxt.in_db    = aturn < TURN_DEADBAND;
    // Inboard is left when forward and turn share a sign.
    s2_nxt.inb_left = fsel[15] == tsel[15];
    if (s2_nxt.tip) begin
      s2_nxt.left_mix = -$signed({tsel[15], tsel});
    end else begin
      s2_nxt.left_mix = $signed({fsel[15], fsel}) - $signed({tsel[15], tsel});
    end
    s2_nxt.right_mix = s2_nxt.tip ? $signed({tsel[15], tsel})
                                  : $signed({fsel[15], fsel}) + $signed({tsel[15], tsel});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

endmodule

### sv/adbm_scale.sv
// Inboard scaling: deadband product, division by 6400 and brake level.
module adbm_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        max_braking,
  input  logic              up_valid,
  output logic              up_ready,
  input  adbm_pkg::shape_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output adbm_pkg::scale_t  dn_data
);
  import adbm_pkg::*;

  logic        v3_r, v4_r;
  logic        rdy3, rdy4;
  logic [12:0] keep_frac;
  logic [14:0] over_db;
  logic [28:0] pmag_nxt, pmag_r;
  logic [19:0] bprod_nxt, bprod_r;
  shape_t      s3_r;
  logic [19:0] pdiv;
  logic [40:0] qprod;
  logic [2:0]  steps;
  scale_t      s4_nxt, s4_r;

  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign up_ready = rdy3;

  // Stage 3: the two products. Their values only matter on the matching side
  // of the deadband.
  always_comb begin
    keep_frac = 13'(TURN_DEADBAND - up_data.aturn);
    over_db   = 15'(up_data.aturn - TURN_DEADBAND);
    pmag_nxt  = up_data.afwd * keep_frac;
    bprod_nxt = over_db * ({1'b0, max_braking} + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= up_valid;
    end
    if (rdy3 && up_valid) begin
      s3_r    <= up_data;
      pmag_r  <= pmag_nxt;
      bprod_r <= bprod_nxt;
    end
  end

  // Stage 4: quotient by 6400 and the clamped brake level.
  always_comb begin
    pdiv  = pmag_r[27:DB_SHIFT];
    qprod = pdiv * RECIP_25;
    // The level saturates at four whole spans, so only four thresholds count.
    steps = 3'(bprod_r >= BRAKE_SPAN) + 3'(bprod_r >= 20'(2 * BRAKE_SPAN))
          + 3'(bprod_r >= 20'(3 * BRAKE_SPAN)) + 3'(bprod_r >= 20'(4 * BRAKE_SPAN));

    s4_nxt.left_mix  = s3_r.left_mix;
    s4_nxt.right_mix = s3_r.right_mix;
    s4_nxt.qmag      = qprod[RECIP_SHIFT+15:RECIP_SHIFT];
    s4_nxt.level     = {steps, 1'b0};
    s4_nxt.fneg      = s3_r.fneg;
    s4_nxt.tip       = s3_r.tip;
    s4_nxt.in_db     = s3_r.in_db;
    s4_nxt.inb_left  = s3_r.inb_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
    if (rdy4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign dn_valid = v4_r;
  assign dn_data  = s4_r;

endmodule

### sv/adbm_out.sv
// Output stage: selects inboard power and brake commands into the result register.
module adbm_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  adbm_pkg::scale_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output adbm_pkg::result_t dn_data
);
  import adbm_pkg::*;

  logic               v5_r;
  logic               rdy5;
  logic signed [16:0] inb_power;
  result_t            res_nxt, res_r;

  assign rdy5     = !v5_r || dn_ready;
  assign up_ready = rdy5;

  always_comb begin
    inb_power = up_data.fneg ? -$signed({1'b0, up_data.qmag}) : $signed({1'b0, up_data.qmag});

    res_nxt.left_power  = up_data.left_mix;
    res_nxt.right_power = up_data.right_mix;
    res_nxt.left_cmd    = CMD_KEEP;
    res_nxt.left_level  = 4'd0;
    res_nxt.right_cmd   = CMD_KEEP;
    res_nxt.right_level = 4'd0;

    if (up_data.tip) begin
      res_nxt.left_cmd  = CMD_COAST;
      res_nxt.right_cmd = CMD_COAST;
    end else if (up_data.in_db) begin
      if (up_data.inb_left) begin
        res_nxt.left_power = inb_power;
      end else begin
        res_nxt.right_power = inb_power;
      end
    end else if (up_data.inb_left) begin
      res_nxt.left_power = 17'sd0;
      res_nxt.left_cmd   = CMD_SET;
      res_nxt.left_level = up_data.level;
    end else begin
      res_nxt.right_power = 17'sd0;
      res_nxt.right_cmd   = CMD_SET;
      res_nxt.right_level = up_data.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= up_valid;
    end
    if (rdy5 && up_valid) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = v5_r;
  assign dn_data  = res_r;

endmodule

### sv/arcade_drive_brake_mixer.sv
// Top level of the arcade drive brake mixer: register port and pipeline.
//
// Usage: drive a command pair on the in_ stream (forward in in_tdata[15:0],
// turn in in_tdata[31:16], both signed Q0.15). Each accepted item yields
// exactly one result item on the out_ stream with left/right motor power
// and a brake command and level per side.
// The datapath is a five-stage pipeline: squaring, sign and mode decode,
// the deadband and brake products, the reciprocal divide by 6400, and the
// result register. A result item shows on out_tvalid once it reaches the result
// register and can be taken at the next edge. Throughput is one item per cycle
// while out_tready is high, as every stage can then pass its item on in every
// cycle. Every stage holds its own valid bit and fills when it is empty or the
// stage after it moves, so bubbles are squeezed out while the receiver stalls
// and in_tready drops only when all five stages hold items.
// Reset clears all valid bits and sets squared_inputs to 0 and max_braking
// to 4. The registers sit on the APB-style cfg_ port at byte addresses 0
// and 4; write them only while no item is in flight.
module arcade_drive_brake_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // forward[15:0], turn[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_power[16:0], right_power[33:17], left_brake_cmd[35:34],
  // left_brake_level[39:36], right_brake_cmd[41:40], right_brake_level[45:42], zero[47:46]
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import adbm_pkg::*;

  logic    squared_inputs_r;
  logic [3:0] max_braking_r;
  logic    cfg_write;
  logic    sh_valid, sh_ready, sc_valid, sc_ready;
  shape_t  sh_data;
  scale_t  sc_data;
  result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      squared_inputs_r <= 1'b0;
      max_braking_r    <= MAX_BRAKING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_paddr[2])
        REG_SQUARED_INPUTS: squared_inputs_r <= cfg_pwdata[0];
        REG_MAX_BRAKING:    max_braking_r    <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SQUARED_INPUTS: cfg_prdata = {31'd0, squared_inputs_r};
      REG_MAX_BRAKING:    cfg_prdata = {28'd0, max_braking_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  adbm_shape u_shape (
    .clk            (clk),
    .rst_n          (rst_n),
    .squared_inputs (squared_inputs_r),
    .up_valid       (in_tvalid),
    .up_ready       (in_tready),
    .forward        ($signed(in_tdata[15:0])),
    .turn           ($signed(in_tdata[31:16])),
    .dn_valid       (sh_valid),
    .dn_ready       (sh_ready),
    .dn_data        (sh_data)
  );

  adbm_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_braking (max_braking_r),
    .up_valid    (sh_valid),
    .up_ready    (sh_ready),
    .up_data     (sh_data),
    .dn_valid    (sc_valid),
    .dn_ready    (sc_ready),
    .dn_data     (sc_data)
  );

  adbm_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sc_valid),
    .up_ready (sc_ready),
    .up_data  (sc_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  assign out_tdata = {2'b00, res.right_level, res.right_cmd, res.left_level, res.left_cmd,
                      res.right_power, res.left_power};

endmodule

### sv/adbm_checker.sv
// Port-level checker for the arcade drive brake mixer, bound to the top level.
module adbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import adbm_pkg::*;

  logic [1:0] lcmd, rcmd;
  logic [3:0] llev, rlev;

  assign lcmd = out_tdata[35:34];
  assign llev = out_tdata[39:36];
  assign rcmd = out_tdata[41:40];
  assign rlev = out_tdata[45:42];

  // A held result item stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // An empty result register means the pipeline has room.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  // Only the inboard side may brake, and levels appear only with a set command.
  a_one_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(lcmd == CMD_SET && rcmd == CMD_SET)
                   && (lcmd == CMD_SET || llev == 4'd0)
                   && (rcmd == CMD_SET || rlev == 4'd0))
    else $error("bad brake command pair");

  // Turning in place coasts both sides together.
  a_coast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((lcmd == CMD_COAST) == (rcmd == CMD_COAST)))
    else $error("coast commanded on one side only");

endmodule

bind arcade_drive_brake_mixer adbm_checker u_adbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/arcade_drive_brake_mixer_tb.sv
// Self-checking testbench for the arcade drive brake mixer: stream traffic, register phases.
module arcade_drive_brake_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adbm_pkg::*;

  localparam longint IN_PLACE_LIMIT = 2560;
  localparam longint DEADBAND       = 6400;
  localparam longint BRAKE_REACH    = 26368;
  localparam longint LEVEL_CEILING  = 8;
  localparam int     PHASE_ITEMS    = 228;

  class mix_scoreboard;
    bit         squared_inputs;
    logic [3:0] max_braking;
    result_t    pending_mixes[$];
    int         errors;

    function new();
      squared_inputs = 1'b0;
      max_braking    = MAX_BRAKING_RESET;
      errors         = 0;
    endfunction

    // Computes the drive result for one command pair under the current registers.
    function result_t predict_drive(logic [31:0] data);
      longint  fwd;
      longint  trn;
      longint  left;
      longint  right;
      longint  aturn;
      longint  level;
      bit      inb_left;
      result_t r;
      fwd = longint'($signed(data[15:0]));
      trn = longint'($signed(data[31:16]));
      if (squared_inputs) begin
        fwd = (fwd < 0) ? -((fwd * fwd) / 32768) : (fwd * fwd) / 32768;
        trn = (trn < 0) ? -((trn * trn) / 32768) : (trn * trn) / 32768;
      end
      r.left_cmd    = CMD_KEEP;
      r.right_cmd   = CMD_KEEP;
      r.left_level  = 4'd0;
      r.right_level = 4'd0;
      left  = fwd - trn;
      right = fwd + trn;
      if (((fwd < 0) ? -fwd : fwd) < IN_PLACE_LIMIT) begin
        left        = -trn;
        right       = trn;
        r.left_cmd  = CMD_COAST;
        r.right_cmd = CMD_COAST;
      end else begin
        // The inboard wheel is the one on the inside of the arc, which flips in reverse.
        inb_left = (trn >= 0) ? (fwd >= 0) : (fwd < 0);
        aturn    = (trn < 0) ? -trn : trn;
        if (aturn < DEADBAND) begin
          if (inb_left) begin
            left = (fwd * (DEADBAND - aturn)) / DEADBAND;
          end else begin
            right = (fwd * (DEADBAND - aturn)) / DEADBAND;
          end
        end else begin
          level = 2 * (((aturn - DEADBAND) * (longint'(max_braking) + 1)) / BRAKE_REACH);
          if (level > LEVEL_CEILING) level = LEVEL_CEILING;
          if (inb_left) begin
            left         = 0;
            r.left_cmd   = CMD_SET;
            r.left_level = 4'(level);
          end else begin
            right         = 0;
            r.right_cmd   = CMD_SET;
            r.right_level = 4'(level);
          end
        end
      end
      r.left_power  = 17'(left);
      r.right_power = 17'(right);
      return r;
    endfunction

    function void note_command(logic [31:0] data);
      pending_mixes.push_back(predict_drive(data));
    endfunction

    function void check_field(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [47:0] data);
      result_t want;
      if (pending_mixes.size() == 0) begin
        $error("result item %h arrived with no command pending", data);
        errors++;
        return;
      end
      want = pending_mixes.pop_front();
      check_field("left_power", int'(want.left_power), int'($signed(data[16:0])));
      check_field("right_power", int'(want.right_power), int'($signed(data[33:17])));
      check_field("left_brake_cmd", int'(want.left_cmd), int'(data[35:34]));
      check_field("left_brake_level", int'(want.left_level), int'(data[39:36]));
      check_field("right_brake_cmd", int'(want.right_cmd), int'(data[41:40]));
      check_field("right_brake_level", int'(want.right_level), int'(data[45:42]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // forward[15:0], turn[31:16]
  logic        out_tvalid;
  logic        out_tready;
  // left_power[16:0], right_power[33:17], left_brake_cmd[35:34],
  // left_brake_level[39:36], right_brake_cmd[41:40], right_brake_level[45:42], zero[47:46]
  logic [47:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mix_scoreboard mixer_sb;
  bit            send_calm;

  arcade_drive_brake_mixer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("arcade_drive_brake_mixer regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) mixer_sb.note_command(in_tdata);
    if (rst_n && out_tvalid && out_tready) mixer_sb.check_result(out_tdata);
  end

  // Offers one command pair and returns at the edge where it is taken.
  // Valid is left high so that back-to-back items need no extra edge.
  task automatic send_command(input logic [15:0] fwd, input logic [15:0] trn);
    int gap;
    gap = send_calm ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {trn, fwd};
    do @(posedge clk); while (!in_tready);
  endtask

  // Writes a register, then reads it back through the same port.
  task automatic write_register(input logic reg_index, input logic [31:0] wdata);
    logic [31:0] readback;
    logic [31:0] mask;
    mask = (reg_index == REG_MAX_BRAKING) ? 32'hF : 32'h1;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_index, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_index == REG_SQUARED_INPUTS) begin
      mixer_sb.squared_inputs = wdata[0];
    end else begin
      mixer_sb.max_braking = wdata[3:0];
    end
    if ((readback & mask) != (wdata & mask)) begin
      $error("register %0d readback: expected %0d, got %0d", reg_index, wdata & mask,
             readback & mask);
      mixer_sb.errors++;
    end
  endtask

  task automatic drain_pipeline();
    while (mixer_sb.pending_mixes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Magnitudes cluster around two knees: the plain threshold and the input that
  // lands on it after squaring.
  function automatic logic [15:0] rand_cmd(int knee_a, int knee_b);
    int         mag_v;
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: mag_v = int'($urandom_range(0, knee_a));
      3: mag_v = knee_a - 8 + int'($urandom_range(0, 16));
      4: mag_v = knee_b - 8 + int'($urandom_range(0, 16));
      default: mag_v = 32768 - int'($urandom_range(0, 2));
    endcase
    v = 16'(mag_v);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Receiver: random stalls, calm stretches, and a long hold-off now and then
  // so that the pipeline fills and pushes back on the sender.
  initial begin
    int  stall;
    int  taken;
    bit  calm;
    out_tready <= 1'b0;
    taken = 0;
    calm  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : int'($urandom_range(0, 8));
      if (taken % 600 == 300) stall = 150;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin
    logic       sq;
    logic [3:0] brake_scale;
    mixer_sb    = new();
    send_calm   = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs under the reset registers: extremes, the turn-in-place edge,
    // the deadband edge on both inboard sides, and a brake level step.
    send_command(16'sd0, 16'sd0);
    send_command(16'sd32767, 16'sd0);
    send_command(-16'sd32767, 16'sd0);
    send_command(16'sh8000, 16'sd0);
    send_command(16'sd0, 16'sd32767);
    send_command(16'sd0, 16'sh8000);
    send_command(16'sd2559, 16'sd1000);
    send_command(16'sd2560, 16'sd1000);
    send_command(-16'sd2559, -16'sd1000);
    send_command(-16'sd2560, -16'sd1000);
    send_command(16'sd32767, 16'sd6399);
    send_command(16'sd32767, 16'sd6400);
    send_command(16'sd32767, -16'sd6400);
    send_command(-16'sd32767, 16'sd6400);
    send_command(-16'sd32767, -16'sd6400);
    send_command(16'sd10000, 16'sd11673);
    send_command(16'sd10000, 16'sd11674);
    send_command(-16'sd10000, -16'sd3200);
    send_command(16'sd20000, 16'sd32767);
    send_command(16'sh8000, 16'sh8000);
    send_command(16'sd32767, 16'sd32767);
    send_command(-16'sd1, -16'sd1);
    send_command(16'sd5000, -16'sd6399);
    send_command(-16'sd20000, 16'sd6399);
    in_tvalid <= 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin sq = 1'b1; brake_scale = 4'd0;  end
        1: begin sq = 1'b0; brake_scale = 4'd15; end
        2: begin sq = 1'b1; brake_scale = 4'd15; end
        3: begin sq = 1'b0; brake_scale = 4'd0;  end
        default: begin
          sq          = 1'($urandom_range(0, 1));
          brake_scale = 4'($urandom_range(0, 15));
        end
      endcase
      drain_pipeline();
      // Upper write bits are random; only the register's own bits may stick.
      write_register(REG_SQUARED_INPUTS, ($urandom & 32'hFFFF_FFFE) | {31'd0, sq});
      write_register(REG_MAX_BRAKING, ($urandom & 32'hFFFF_FFF0) | {28'd0, brake_scale});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
        send_command(rand_cmd(2560, 9159), rand_cmd(6400, 14482));
      end
      in_tvalid <= 1'b0;
    end

    drain_pipeline();
    if (mixer_sb.errors == 0 && mixer_sb.pending_mixes.size() == 0) begin
      $display("arcade_drive_brake_mixer regression: pass");
    end else begin
      $display("arcade_drive_brake_mixer regression: fail");
    end
    $finish;
  end

endmodule
